// ----- sv/dual_layer_video_priority_mixer_core_defines.svh -----
// Assertion macros shared by the RTL of the two-plane priority mixer.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef DUAL_LAYER_VIDEO_PRIORITY_MIXER_CORE_DEFINES_SVH
`define DUAL_LAYER_VIDEO_PRIORITY_MIXER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define DLVPM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DLVPM_NEVER(lbl, clk, rst_n, cond, msg) \
    `DLVPM_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define DLVPM_ASSERT(lbl, clk, rst_n, prop, msg)
`define DLVPM_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ----- sv/dlvpm_pkg.sv -----
// Types and constants of the two-plane video priority mixer.
// Depends on nothing; used by the mixer core.
`timescale 1ns / 1ps

package dlvpm_pkg;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [10:0] hclock;
        logic [8:0]  pixel_first;
        logic [8:0]  pixel_second;
        logic [4:0]  address;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        logic [8:0] pixel_out;
        logic [7:0] read_data;
        logic [1:0] target;
        logic       target_is_write;
        logic [4:0] target_address;
        logic [7:0] target_data;
    } rsp_t;

    localparam logic [1:0] OP_MIX   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_STORE = 2'd3;

    localparam logic [1:0] TGT_LOCAL  = 2'd0;
    localparam logic [1:0] TGT_FIRST  = 2'd1;
    localparam logic [1:0] TGT_SECOND = 2'd2;

    localparam logic [1:0] PRI_SPRITE_FIRST = 2'd1;
    localparam logic [1:0] PRI_BACK_FIRST   = 2'd2;

    localparam logic [4:0] ADDR_SET_LO    = 5'h08;
    localparam logic [4:0] ADDR_SET_HI    = 5'h09;
    localparam logic [4:0] ADDR_WIN0_LO   = 5'h0a;
    localparam logic [4:0] ADDR_WIN0_HI   = 5'h0b;
    localparam logic [4:0] ADDR_WIN1_LO   = 5'h0c;
    localparam logic [4:0] ADDR_WIN1_HI   = 5'h0d;
    localparam logic [4:0] ADDR_SELECT    = 5'h0e;
    localparam logic [4:0] ADDR_HIGH_BASE = 5'h18;

    // Address bit 3 clear means the access belongs to a generator; bit 4 picks which.
    localparam int ADDR_LOCAL_BIT = 3;
    localparam int ADDR_GEN_BIT   = 4;

    localparam logic [9:0] WINDOW_BASE    = 10'd64;
    localparam logic [3:0] SETTING_RESET  = 4'h1;
    localparam logic [7:0] HIGH_READBACK  = 8'hff;
    localparam logic [8:0] PIXEL_NONE     = 9'h000;

endpackage

// ----- sv/dual_layer_video_priority_mixer_core.sv -----
// Two-plane video priority mixer with register decode, as a two-register pipeline.
// Depends on dlvpm_pkg and dual_layer_video_priority_mixer_core_defines.svh.
//
//   channel | signals                   | carries
//   --------+---------------------------+-------------------------------------
//   request | req_valid, req_ready, req | one word: opcode, pixels, bus access
//   result  | rsp_valid, rsp_ready, rsp | one word: pixel, readback, target
//
// Each word passes through the input register and then the result register.
// A new word is accepted every cycle while the result is not stalled.
// A stalled result holds both registers once the input register is full.
// Reset clears the valid flags and loads the mode settings, windows and select.
`timescale 1ns / 1ps
`include "dual_layer_video_priority_mixer_core_defines.svh"

module dual_layer_video_priority_mixer_core
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  dlvpm_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output dlvpm_pkg::rsp_t rsp
);
    import dlvpm_pkg::*;

    logic             in_valid_reg;
    req_t             in_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic [3:0][3:0]  settings_reg;
    logic [3:0][3:0]  settings_next;
    logic [1:0][9:0]  win_reg;
    logic [1:0][9:0]  win_next;
    logic             select_reg;
    logic             select_next;
    logic             advance;
    logic [1:0]       mode;
    logic [3:0]       setting;
    logic [1:0]       pri;
    logic             en0;
    logic             en1;
    logic             sp0;
    logic             sp1;
    logic [8:0]       mixed;
    logic [9:0]       half_h;
    logic             local_wr;

    assign advance   = in_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        half_h = in_reg.hclock[10:1];
        for (int k = 0; k < 2; k++)
        begin
            mode[k] = !(win_reg[k] >= WINDOW_BASE && (win_reg[k] - WINDOW_BASE) >= half_h);
        end
        setting = settings_reg[mode];
        pri     = setting[3:2];
        en0     = setting[0] && (in_reg.pixel_first[3:0] != 4'd0);
        en1     = setting[1] && (in_reg.pixel_second[3:0] != 4'd0);
        sp0     = in_reg.pixel_first[8];
        sp1     = in_reg.pixel_second[8];
        mixed   = PIXEL_NONE;
        case (pri)
            PRI_SPRITE_FIRST:
            begin
                if (en0 && sp0)
                    mixed = in_reg.pixel_first;
                else if (en1 && sp1)
                    mixed = in_reg.pixel_second;
                else if (en0)
                    mixed = in_reg.pixel_first;
                else if (en1)
                    mixed = in_reg.pixel_second;
            end
            PRI_BACK_FIRST:
            begin
                if (en0 && !sp0)
                    mixed = in_reg.pixel_first;
                else if (en1)
                    mixed = in_reg.pixel_second;
                else if (en0)
                    mixed = in_reg.pixel_first;
            end
            default:
            begin
                if (en0)
                    mixed = in_reg.pixel_first;
                else if (en1)
                    mixed = in_reg.pixel_second;
            end
        endcase
    end

    always_comb
    begin
        rsp_next      = '0;
        settings_next = settings_reg;
        win_next      = win_reg;
        select_next   = select_reg;
        local_wr      = 1'b0;
        unique case (in_reg.opcode) inside
            OP_MIX:
            begin
                rsp_next.pixel_out = mixed;
            end
            OP_STORE:
            begin
                rsp_next.target          = select_reg ? TGT_SECOND : TGT_FIRST;
                rsp_next.target_is_write = 1'b1;
                rsp_next.target_address  = {3'd0, in_reg.address[1:0]};
                rsp_next.target_data     = in_reg.write_data;
            end
            OP_READ, OP_WRITE:
            begin
                if (!in_reg.address[ADDR_LOCAL_BIT])
                begin
                    rsp_next.target         = in_reg.address[ADDR_GEN_BIT] ? TGT_SECOND
                                                                           : TGT_FIRST;
                    rsp_next.target_address = in_reg.address;
                    if (in_reg.opcode == OP_WRITE)
                    begin
                        rsp_next.target_is_write = 1'b1;
                        rsp_next.target_data     = in_reg.write_data;
                    end
                end
                else if (in_reg.opcode == OP_WRITE)
                begin
                    local_wr = 1'b1;
                end
                else
                begin
                    unique case (in_reg.address)
                        ADDR_SET_LO:  rsp_next.read_data = {settings_reg[1], settings_reg[0]};
                        ADDR_SET_HI:  rsp_next.read_data = {settings_reg[3], settings_reg[2]};
                        ADDR_WIN0_LO: rsp_next.read_data = win_reg[0][7:0];
                        ADDR_WIN0_HI: rsp_next.read_data = {6'd0, win_reg[0][9:8]};
                        ADDR_WIN1_LO: rsp_next.read_data = win_reg[1][7:0];
                        ADDR_WIN1_HI: rsp_next.read_data = {6'd0, win_reg[1][9:8]};
                        default:
                            rsp_next.read_data = (in_reg.address >= ADDR_HIGH_BASE)
                                                 ? HIGH_READBACK : 8'd0;
                    endcase
                end
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase

        if (local_wr && advance)
        begin
            unique case (in_reg.address)
                ADDR_SET_LO:
                begin
                    settings_next[0] = in_reg.write_data[3:0];
                    settings_next[1] = in_reg.write_data[7:4];
                end
                ADDR_SET_HI:
                begin
                    settings_next[2] = in_reg.write_data[3:0];
                    settings_next[3] = in_reg.write_data[7:4];
                end
                ADDR_WIN0_LO: win_next[0][7:0] = in_reg.write_data;
                ADDR_WIN0_HI: win_next[0][9:8] = in_reg.write_data[1:0];
                ADDR_WIN1_LO: win_next[1][7:0] = in_reg.write_data;
                ADDR_WIN1_HI: win_next[1][9:8] = in_reg.write_data[1:0];
                ADDR_SELECT:  select_next      = in_reg.write_data[0];
                default:      select_next      = select_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            settings_reg  <= {4{SETTING_RESET}};
            win_reg       <= '0;
            select_reg    <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                in_valid_reg <= req_valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            settings_reg <= settings_next;
            win_reg      <= win_next;
            select_reg   <= select_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            in_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    `DLVPM_NEVER(a_target_code, clk, rst_n,
        rsp_valid_reg && rsp_reg.target == 2'd3,
        "Result names an unknown target")
    `DLVPM_ASSERT(a_pixel_alone, clk, rst_n,
        (rsp_valid_reg && rsp_reg.pixel_out != PIXEL_NONE)
            |-> (rsp_reg.target == TGT_LOCAL && rsp_reg.read_data == 8'd0),
        "Mixed pixel shares its word with a bus result")
    `DLVPM_ASSERT(a_pixel_colour, clk, rst_n,
        (rsp_valid_reg && rsp_reg.pixel_out != PIXEL_NONE) |-> (rsp_reg.pixel_out[3:0] != 4'd0),
        "Transparent pixel chosen")
    `DLVPM_ASSERT(a_accept_lands, clk, rst_n,
        (req_valid && req_ready) |=> in_valid_reg,
        "Accepted word lost from the input register")
    `DLVPM_ASSERT(a_state_quiet, clk, rst_n,
        !(advance && in_reg.opcode == OP_WRITE)
            |=> ($stable(settings_reg) && $stable(win_reg) && $stable(select_reg)),
        "Local state changed without a register write")

endmodule

// ----- verif/dlvpm_mix_checker.sv -----
// Checker for the two-plane priority mixer: predicts each result word from the accepted requests.
// Depends on dlvpm_pkg; instantiated beside the block by dual_layer_video_priority_mixer_core_tb.
`timescale 1ns / 1ps

module dlvpm_mix_checker
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_ready,
    input  dlvpm_pkg::req_t req,
    input  logic            rsp_valid,
    input  logic            rsp_ready,
    input  dlvpm_pkg::rsp_t rsp,
    output int              mismatch_count,
    output int              words_outstanding
);
    import dlvpm_pkg::*;

    logic [3:0] mode_setting [4];
    logic [9:0] window_limit [2];
    logic       store_sel;
    rsp_t       predicted_words [$];
    rsp_t       oldest;

    function automatic logic window_open(input logic [9:0] lim, input logic [10:0] hc);
        return (lim >= WINDOW_BASE) && ((lim - WINDOW_BASE) >= hc[10:1]);
    endfunction

    function automatic logic [8:0] mixed_pixel(input logic [3:0] s, input logic [8:0] p0,
                                                input logic [8:0] p1);
        logic en0, en1, sp0, sp1;
        logic [8:0] pick;
        en0 = s[0] && (p0[3:0] != 4'd0);
        en1 = s[1] && (p1[3:0] != 4'd0);
        sp0 = p0[8];
        sp1 = p1[8];
        pick = PIXEL_NONE;
        case (s[3:2])
            PRI_SPRITE_FIRST:
            begin
                if (en0 && sp0)
                    pick = p0;
                else if (en1 && sp1)
                    pick = p1;
                else if (en0)
                    pick = p0;
                else if (en1)
                    pick = p1;
            end
            PRI_BACK_FIRST:
            begin
                if (en0 && !sp0)
                    pick = p0;
                else if (en1)
                    pick = p1;
                else if (en0)
                    pick = p0;
            end
            default:
            begin
                if (en0)
                    pick = p0;
                else if (en1)
                    pick = p1;
            end
        endcase
        return pick;
    endfunction

    function automatic logic [7:0] register_readback(input logic [4:0] a);
        logic [7:0] d;
        case (a)
            ADDR_SET_LO:  d = {mode_setting[1], mode_setting[0]};
            ADDR_SET_HI:  d = {mode_setting[3], mode_setting[2]};
            ADDR_WIN0_LO: d = window_limit[0][7:0];
            ADDR_WIN0_HI: d = {6'd0, window_limit[0][9:8]};
            ADDR_WIN1_LO: d = window_limit[1][7:0];
            ADDR_WIN1_HI: d = {6'd0, window_limit[1][9:8]};
            default:      d = (a >= ADDR_HIGH_BASE) ? HIGH_READBACK : 8'h00;
        endcase
        return d;
    endfunction

    function automatic void register_update(input logic [4:0] a, input logic [7:0] d);
        case (a)
            ADDR_SET_LO:
            begin
                mode_setting[0] = d[3:0];
                mode_setting[1] = d[7:4];
            end
            ADDR_SET_HI:
            begin
                mode_setting[2] = d[3:0];
                mode_setting[3] = d[7:4];
            end
            ADDR_WIN0_LO: window_limit[0][7:0] = d;
            ADDR_WIN0_HI: window_limit[0][9:8] = d[1:0];
            ADDR_WIN1_LO: window_limit[1][7:0] = d;
            ADDR_WIN1_HI: window_limit[1][9:8] = d[1:0];
            ADDR_SELECT:  store_sel = d[0];
            default:      ;
        endcase
    endfunction

    function automatic rsp_t predict_response(input req_t w);
        rsp_t r;
        logic [1:0] mode;
        r = '0;
        case (w.opcode)
            OP_MIX:
            begin
                mode = {!window_open(window_limit[1], w.hclock),
                        !window_open(window_limit[0], w.hclock)};
                r.pixel_out = mixed_pixel(mode_setting[mode], w.pixel_first, w.pixel_second);
            end
            OP_STORE:
            begin
                r.target = store_sel ? TGT_SECOND : TGT_FIRST;
                r.target_is_write = 1'b1;
                r.target_address = {3'd0, w.address[1:0]};
                r.target_data = w.write_data;
            end
            default:
            begin
                if (!w.address[ADDR_LOCAL_BIT])
                begin
                    r.target = w.address[ADDR_GEN_BIT] ? TGT_SECOND : TGT_FIRST;
                    r.target_address = w.address;
                    if (w.opcode == OP_WRITE)
                    begin
                        r.target_is_write = 1'b1;
                        r.target_data = w.write_data;
                    end
                end
                else if (w.opcode == OP_WRITE)
                    register_update(w.address, w.write_data);
                else
                    r.read_data = register_readback(w.address);
            end
        endcase
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [8:0] want,
                                          input logic [8:0] got);
        if (got !== want)
        begin
            $error("%s expected %0h got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
                mode_setting[k] = SETTING_RESET;
            window_limit[0] = '0;
            window_limit[1] = '0;
            store_sel = 1'b0;
            mismatch_count = 0;
            predicted_words.delete();
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (predicted_words.size() == 0)
                begin
                    $error("result word %h arrived with no prediction waiting", rsp);
                    mismatch_count++;
                end
                else
                begin
                    oldest = predicted_words.pop_front();
                    compare_field("pixel_out", oldest.pixel_out, rsp.pixel_out);
                    compare_field("read_data", 9'(oldest.read_data), 9'(rsp.read_data));
                    compare_field("target", 9'(oldest.target), 9'(rsp.target));
                    compare_field("target_is_write", 9'(oldest.target_is_write),
                                  9'(rsp.target_is_write));
                    compare_field("target_address", 9'(oldest.target_address),
                                  9'(rsp.target_address));
                    compare_field("target_data", 9'(oldest.target_data), 9'(rsp.target_data));
                end
            end
            if (req_valid && req_ready)
                predicted_words.push_back(predict_response(req));
        end
        words_outstanding = predicted_words.size();
    end

endmodule

// ----- verif/dual_layer_video_priority_mixer_core_tb.sv -----
// Top of the mixer testbench: clock, reset, request and result traffic, watchdog and verdict.
// Depends on dlvpm_pkg, dual_layer_video_priority_mixer_core and dlvpm_mix_checker.
`timescale 1ns / 1ps

module dual_layer_video_priority_mixer_core_tb;
    import dlvpm_pkg::*;

    localparam int RANDOM_WORDS = 525;
    localparam int IDLE_LIMIT   = 4000;
    localparam int LONG_HOLD    = 300;
    localparam logic [4:0] GEN_FIRST_BASE  = 5'h00;
    localparam logic [4:0] GEN_SECOND_BASE = 5'h10;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;
    int   mismatch_count;
    int   words_outstanding;
    int   idle_cycles = 0;
    int   words_sent = 0;
    int   results_taken = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    dual_layer_video_priority_mixer_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    dlvpm_mix_checker i_checker
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .req_valid         (req_valid),
        .req_ready         (req_ready),
        .req               (req),
        .rsp_valid         (rsp_valid),
        .rsp_ready         (rsp_ready),
        .rsp               (rsp),
        .mismatch_count    (mismatch_count),
        .words_outstanding (words_outstanding)
    );

    // Every eighty words the first twenty go back to back.
    function automatic int draw_gap(input int n);
        if ((n % 80) < 20)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    function automatic req_t bus_word(input logic [1:0] op, input logic [4:0] a,
                                      input logic [7:0] d);
        req_t w;
        w = '0;
        w.opcode = op;
        w.address = a;
        w.write_data = d;
        return w;
    endfunction

    function automatic req_t mix_word(input logic [10:0] hc, input logic [8:0] p0,
                                      input logic [8:0] p1);
        req_t w;
        w = '0;
        w.opcode = OP_MIX;
        w.hclock = hc;
        w.pixel_first = p0;
        w.pixel_second = p1;
        return w;
    endfunction

    task automatic send_word(input req_t w);
        int gap;
        gap = draw_gap(words_sent);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (words_outstanding != 0);
    endtask

    initial
    begin
        req_t w;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_word(bus_word(OP_READ, ADDR_SET_LO, 8'h00));
        send_word(bus_word(OP_READ, ADDR_HIGH_BASE + 5'd7, 8'h00));
        send_word(bus_word(OP_READ, ADDR_SELECT + 5'd1, 8'h00));
        send_word(bus_word(OP_WRITE, ADDR_SELECT + 5'd1, 8'hff));
        send_word(bus_word(OP_WRITE, ADDR_HIGH_BASE, 8'haa));
        send_word(mix_word(11'd0, 9'h1f0, 9'h1ff));
        send_word(mix_word(11'd0, 9'h1ff, 9'h0ff));
        send_word(bus_word(OP_WRITE, ADDR_SET_LO, 8'h96));
        send_word(bus_word(OP_WRITE, ADDR_SET_HI, 8'hfe));
        send_word(bus_word(OP_WRITE, ADDR_WIN0_HI, 8'hff));
        send_word(bus_word(OP_WRITE, ADDR_WIN0_LO, 8'hff));
        send_word(bus_word(OP_READ, ADDR_WIN0_HI, 8'h00));
        send_word(bus_word(OP_WRITE, ADDR_WIN1_HI, 8'h00));
        send_word(bus_word(OP_WRITE, ADDR_WIN1_LO, 8'h40));
        send_word(mix_word(11'd0, 9'h10f, 9'h105));
        send_word(mix_word(11'd2047, 9'h10f, 9'h105));
        send_word(mix_word(11'd2, 9'h10f, 9'h105));
        send_word(bus_word(OP_WRITE, ADDR_SELECT, 8'h01));
        send_word(bus_word(OP_READ, ADDR_SELECT, 8'h00));
        send_word(bus_word(OP_STORE, ADDR_HIGH_BASE + 5'd7, 8'ha5));
        send_word(bus_word(OP_WRITE, ADDR_SELECT, 8'h00));
        send_word(bus_word(OP_STORE, GEN_FIRST_BASE, 8'h5a));
        send_word(bus_word(OP_READ, GEN_FIRST_BASE, 8'h00));
        send_word(bus_word(OP_WRITE, GEN_SECOND_BASE + 5'd7, 8'hff));
        send_word(bus_word(OP_READ, GEN_SECOND_BASE, 8'h00));
        send_word(bus_word(OP_WRITE, GEN_FIRST_BASE + 5'd7, 8'h00));

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS / 2)
                drain_results();
            case ($urandom_range(0, 9))
                0, 1:    w.opcode = OP_WRITE;
                2:       w.opcode = OP_READ;
                3:       w.opcode = OP_STORE;
                default: w.opcode = OP_MIX;
            endcase
            w.hclock = 11'($urandom_range(0, 2047));
            w.pixel_first = 9'($urandom_range(0, 511));
            w.pixel_second = 9'($urandom_range(0, 511));
            if ($urandom_range(0, 7) == 0)
                w.pixel_first[3:0] = 4'd0;
            if ($urandom_range(0, 7) == 0)
                w.pixel_second[3:0] = 4'd0;
            if ($urandom_range(0, 1) == 1)
                w.address = 5'($urandom_range(ADDR_SET_LO, ADDR_SELECT));
            else
                w.address = 5'($urandom_range(0, 31));
            w.write_data = 8'($urandom_range(0, 255));
            send_word(w);
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("dual_layer_video_priority_mixer_core_tb: clean");
        else
            $display("dual_layer_video_priority_mixer_core_tb: errors");
        $finish;
    end

    // The receiver holds off for a long stretch twice so that the block fills and stalls.
    initial
    begin
        int stall;
        rsp_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (results_taken == 60 || results_taken == 320)
                stall = LONG_HOLD;
            else
                stall = draw_gap(results_taken);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            results_taken++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("dual_layer_video_priority_mixer_core_tb: errors");
            $finish;
        end
    end

endmodule
